[rtl/sl7seg_pkg.sv]
// Package for the serial line to seven-segment display core.
// Holds shared constants, the digit font and the pattern update type.
// No dependencies.
`default_nettype none

package sl7seg_pkg;

    // Default number of bytes a line may hold before the write index wraps.
    localparam int LINE_LIMIT_DEFAULT = 20;

    // Configuration register indexes.
    localparam logic CFG_SCAN_COUNT  = 1'b0;
    localparam logic CFG_FIRST_DIGIT = 1'b1;

    // Control characters and command letters.
    localparam logic [7:0] CHAR_CR = 8'h0d;
    localparam logic [7:0] CHAR_LF = 8'h0a;
    localparam logic [7:0] CHAR_R  = 8'h52;
    localparam logic [7:0] CHAR_L  = 8'h4c;
    localparam logic [7:0] CHAR_H  = 8'h48;

    // Segment patterns for letters, bit 0 is segment a.
    localparam logic [7:0] SEG_L     = 8'h38;
    localparam logic [7:0] SEG_H     = 8'h76;
    localparam logic [7:0] SEG_R     = 8'h50;
    localparam logic [7:0] SEG_E     = 8'h79;
    localparam logic [7:0] SEG_S     = 8'h6d;
    localparam logic [7:0] SEG_T     = 8'h78;
    localparam logic [7:0] SEG_BLANK = 8'h00;

    // Number of scanned digit positions and the reset scan count.
    localparam int          NUM_DIGITS       = 8;
    localparam logic [3:0]  SCAN_COUNT_RESET = 4'd8;

    // Writes to the first four display patterns produced by a complete line.
    typedef struct packed {
        logic [3:0]      we;
        logic [3:0][7:0] value;
    } pattern_update_t;

    // Seven-segment glyph of an ASCII digit; anything else is blank.
    function automatic logic [7:0] glyph(input logic [7:0] c);
        logic [7:0] g;
        case (c)
            8'h30:   g = 8'h3f;
            8'h31:   g = 8'h06;
            8'h32:   g = 8'h5b;
            8'h33:   g = 8'h4f;
            8'h34:   g = 8'h66;
            8'h35:   g = 8'h6d;
            8'h36:   g = 8'h7d;
            8'h37:   g = 8'h07;
            8'h38:   g = 8'h7f;
            8'h39:   g = 8'h6f;
            default: g = SEG_BLANK;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

[rtl/sl7seg_line.sv]
// Line collector and command decoder for the seven-segment core.
// Gathers received bytes into a line and decodes the command on CR LF.
// Depends on sl7seg_pkg.
`default_nettype none

module sl7seg_line #(
    parameter int LINE_LIMIT = sl7seg_pkg::LINE_LIMIT_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         byte_valid,
    input  wire logic [7:0]                   byte_data,
    output      sl7seg_pkg::pattern_update_t  update
);

    localparam int IDX_W = $clog2(LINE_LIMIT);

    logic [2:0][7:0]  chars_reg;
    logic [IDX_W-1:0] write_index_reg, write_index_next;
    logic [IDX_W-1:0] line_length_reg, line_length_next;
    logic             zero_seen_reg, zero_seen_next;
    logic             cr_seen_reg, cr_seen_next;
    logic             store;
    logic [IDX_W:0]   index_inc;

    // Line state update for one received byte.
    always_comb
    begin
        write_index_next = write_index_reg;
        line_length_next = line_length_reg;
        zero_seen_next   = zero_seen_reg;
        cr_seen_next     = cr_seen_reg;
        store            = 1'b0;
        index_inc        = {1'b0, write_index_reg} + (IDX_W+1)'(1);
        if (byte_valid)
        begin
            if (!cr_seen_reg)
            begin
                if (byte_data == sl7seg_pkg::CHAR_CR)
                begin
                    cr_seen_next = 1'b1;
                end
                else
                begin
                    store = 1'b1;
                    if (!zero_seen_reg)
                    begin
                        if (byte_data == 8'h00)
                            zero_seen_next = 1'b1;
                        else
                            line_length_next = line_length_reg + IDX_W'(1);
                    end
                    if (index_inc == (IDX_W+1)'(LINE_LIMIT))
                    begin
                        write_index_next = '0;
                        line_length_next = '0;
                        zero_seen_next   = 1'b0;
                    end
                    else
                    begin
                        write_index_next = index_inc[IDX_W-1:0];
                    end
                end
            end
            else
            begin
                // A CR is pending: the line either completes or is dropped.
                cr_seen_next     = 1'b0;
                write_index_next = '0;
                line_length_next = '0;
                zero_seen_next   = 1'b0;
            end
        end
    end

    // Command decode for a complete line.
    always_comb
    begin
        update.we    = 4'b0000;
        update.value = '0;
        if (byte_valid && cr_seen_reg && byte_data == sl7seg_pkg::CHAR_LF)
        begin
            if (line_length_reg == IDX_W'(1))
            begin
                update.we = 4'b1111;
                if (chars_reg[0] == sl7seg_pkg::CHAR_R)
                begin
                    update.value[0] = sl7seg_pkg::SEG_R;
                    update.value[1] = sl7seg_pkg::SEG_E;
                    update.value[2] = sl7seg_pkg::SEG_S;
                    update.value[3] = sl7seg_pkg::SEG_T;
                end
                else
                begin
                    update.value[0] = sl7seg_pkg::glyph(chars_reg[0]);
                end
            end
            else if (line_length_reg == IDX_W'(2))
            begin
                update.we       = 4'b1111;
                update.value[0] = sl7seg_pkg::glyph(chars_reg[0]);
                if (chars_reg[1] == sl7seg_pkg::CHAR_L)
                    update.value[1] = sl7seg_pkg::SEG_L;
                else if (chars_reg[1] == sl7seg_pkg::CHAR_H)
                    update.value[1] = sl7seg_pkg::SEG_H;
                else
                    update.value[1] = sl7seg_pkg::glyph(chars_reg[1]);
            end
            else if (line_length_reg == IDX_W'(3))
            begin
                // The middle position changes only for the letters L and H.
                update.we       = 4'b1101;
                update.value[0] = sl7seg_pkg::glyph(chars_reg[0]);
                update.value[2] = sl7seg_pkg::glyph(chars_reg[2]);
                if (chars_reg[1] == sl7seg_pkg::CHAR_L)
                begin
                    update.we[1]    = 1'b1;
                    update.value[1] = sl7seg_pkg::SEG_L;
                end
                else if (chars_reg[1] == sl7seg_pkg::CHAR_H)
                begin
                    update.we[1]    = 1'b1;
                    update.value[1] = sl7seg_pkg::SEG_H;
                end
            end
        end
    end

    // Line control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_index_reg <= '0;
            line_length_reg <= '0;
            zero_seen_reg   <= 1'b0;
            cr_seen_reg     <= 1'b0;
        end
        else
        begin
            write_index_reg <= write_index_next;
            line_length_reg <= line_length_next;
            zero_seen_reg   <= zero_seen_next;
            cr_seen_reg     <= cr_seen_next;
        end
    end

    // The first three bytes of the line are kept; later ones are only counted.
    always_ff @(posedge clk)
    begin
        if (store && write_index_reg < IDX_W'(3))
            chars_reg[write_index_reg[1:0]] <= byte_data;
    end

endmodule

`default_nettype wire

[rtl/serial_line_to_seven_segment_core.sv]
// Top level of the serial line to seven-segment display core.
// Input register, display pattern store, scan logic and result register.
// Depends on sl7seg_pkg and sl7seg_line.
//
// Usage: the slave stream carries one transaction per received serial byte
// (s_tuser = 0, byte in s_tdata) or per display scan tick (s_tuser = 1).
// Bytes build a command line ending in CR LF and produce no output. Each
// tick produces one master transaction: the active-low digit select in
// m_tdata[7:0] and that digit's segment pattern in m_tdata[15:8], after
// which the scan moves to the next position.
// A tick's result passes through the input register and then the result
// register, where it is held until the receiver takes it.
// Throughput: one transaction per cycle while the receiver takes results,
// as the line and scan registers update between the input and result registers.
// When the receiver stalls, the result register holds its transaction;
// bytes keep flowing through the input register until a tick reaches it,
// which then waits there while s_tready is low.
// Reset clears the line state, all display patterns (blank), the scan
// position, and sets scan_count to 8 and first_digit to 0. The cfg port
// must be written only while the core is idle; the core does not enforce it.
`default_nettype none

module serial_line_to_seven_segment_core #(
    parameter int LINE_LIMIT = sl7seg_pkg::LINE_LIMIT_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Slave stream.
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic        s_tuser,   // [0] req_type
    // Master stream.
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [15:0] m_tdata,   // [7:0] digit_select, [15:8] segments
    // Configuration write port.
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [3:0]  cfg_data
);

    logic                          in_valid_reg;
    logic                          in_tick_reg;
    logic [7:0]                    in_byte_reg;
    logic                          stage_fire;
    logic                          tick_fire;
    logic [3:0]                    scan_count_reg;
    logic [2:0]                    first_digit_reg;
    logic [7:0][7:0]               patterns_reg;
    logic [2:0]                    scan_index_reg, scan_index_next;
    logic [3:0]                    scan_inc;
    logic [2:0]                    sel;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [15:0]                   m_tdata_reg;
    sl7seg_pkg::pattern_update_t   update;

    // The stage finishes a byte at once and a tick when the result slot frees.
    assign stage_fire = in_valid_reg && (!in_tick_reg || !m_tvalid_reg || m_tready);
    assign tick_fire  = stage_fire && in_tick_reg;
    assign s_tready   = !in_valid_reg || stage_fire;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_tick_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    // Line collection and command decode.
    sl7seg_line #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_line (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (stage_fire && !in_tick_reg),
        .byte_data  (in_byte_reg),
        .update     (update)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_count_reg  <= sl7seg_pkg::SCAN_COUNT_RESET;
            first_digit_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sl7seg_pkg::CFG_SCAN_COUNT:  scan_count_reg  <= cfg_data;
                sl7seg_pkg::CFG_FIRST_DIGIT: first_digit_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Display patterns; a complete line of one to three characters writes into the first four.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            patterns_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (update.we[i])
                    patterns_reg[i] <= update.value[i];
            end
        end
    end

    // Scan position: wraps at scan_count or after the last digit.
    always_comb
    begin
        scan_inc        = {1'b0, scan_index_reg} + 4'd1;
        scan_index_next = scan_index_reg;
        if (tick_fire)
        begin
            if (scan_inc == scan_count_reg || scan_inc >= 4'(sl7seg_pkg::NUM_DIGITS))
                scan_index_next = '0;
            else
                scan_index_next = scan_inc[2:0];
        end
    end

    assign sel = scan_index_reg + first_digit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scan_index_reg <= '0;
        else
            scan_index_reg <= scan_index_next;
    end

    // Result register.
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (tick_fire)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    always_ff @(posedge clk)
    begin
        if (tick_fire)
            m_tdata_reg <= {patterns_reg[scan_index_reg], ~(8'h01 << sel)};
    end

`ifndef NO_ASSERTIONS
    // Every valid result selects exactly one digit.
    a_one_cold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $countones(m_tdata[7:0]) == 7)
        else $error("digit select is not one-cold");

    // A finished tick always shows up in the result register.
    a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
        tick_fire |=> m_tvalid)
        else $error("tick finished without a result");

    // An item that cannot finish stays in the input register unchanged.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !stage_fire |=> in_valid_reg && $stable(in_byte_reg)
            && $stable(in_tick_reg))
        else $error("stalled input item was lost");
`endif

endmodule

`default_nettype wire

[tb/sl7seg_tb_pkg.sv]
// Shared testbench definitions for the serial line to seven-segment core.
// Holds the request kinds carried on s_tuser and the characters used by the stimulus.
// Depends on nothing.
package sl7seg_tb_pkg;

    // Kind of a slave stream transaction, as carried on s_tuser.
    typedef enum logic {
        REQ_BYTE = 1'b0,
        REQ_TICK = 1'b1
    } req_kind_t;

    // Characters that bound the digit range, and the byte that ends the line length.
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_NUL  = 8'h00;

endpackage

[tb/sl7seg_scan_checker.sv]
// Checker for the serial line to seven-segment core: tracks the line and scan state,
// predicts each tick's digit select and segments, and compares them with the master stream.
// Depends on sl7seg_pkg and sl7seg_tb_pkg.
module sl7seg_scan_checker #(
    parameter int LINE_LIMIT = sl7seg_pkg::LINE_LIMIT_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic        s_tuser,   // [0] req_type
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,   // [7:0] digit_select, [15:8] segments
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [3:0]  cfg_data,
    output int               failures,
    output int               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import sl7seg_pkg::*;
    import sl7seg_tb_pkg::*;

    // One scan result, laid out as on m_tdata.
    typedef struct packed {
        logic [7:0] segments;
        logic [7:0] digit_select;
    } scan_result_t;

    // Scan results still owed by the core, oldest first.
    scan_result_t scan_results_due[$];

    // Shadow of the core's line, display and scan state.
    logic [7:0] line_head [3];
    logic [4:0] write_pos;
    logic [4:0] text_len;
    logic       nul_found;
    logic       cr_pending;
    logic [7:0] shown [NUM_DIGITS];
    logic [2:0] scan_pos;
    logic [3:0] scan_limit;
    logic [2:0] select_offset;

    // Segment shape of an ASCII digit; every other byte is blank.
    function automatic logic [7:0] shape_of(input logic [7:0] c);
        logic [7:0] s;
        s = SEG_BLANK;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            case (c[3:0])
                4'd0: s = 8'h3f;
                4'd1: s = 8'h06;
                4'd2: s = 8'h5b;
                4'd3: s = 8'h4f;
                4'd4: s = 8'h66;
                4'd5: s = 8'h6d;
                4'd6: s = 8'h7d;
                4'd7: s = 8'h07;
                4'd8: s = 8'h7f;
                default: s = 8'h6f;
            endcase
        end
        return s;
    endfunction

    // Line assembly and command decode for one received byte.
    task automatic absorb_rx_byte(input logic [7:0] b);
        if (cr_pending)
        begin
            // The byte after CR closes the line: LF applies it, anything else drops it.
            cr_pending = 1'b0;
            if (b == CHAR_LF)
            begin
                case (text_len)
                    5'd1:
                    begin
                        if (line_head[0] == CHAR_R)
                        begin
                            shown[0] = SEG_R;
                            shown[1] = SEG_E;
                            shown[2] = SEG_S;
                            shown[3] = SEG_T;
                        end
                        else
                        begin
                            shown[0] = shape_of(line_head[0]);
                            shown[1] = SEG_BLANK;
                            shown[2] = SEG_BLANK;
                            shown[3] = SEG_BLANK;
                        end
                    end
                    5'd2:
                    begin
                        shown[0] = shape_of(line_head[0]);
                        if (line_head[1] == CHAR_L)
                            shown[1] = SEG_L;
                        else if (line_head[1] == CHAR_H)
                            shown[1] = SEG_H;
                        else
                            shown[1] = shape_of(line_head[1]);
                        shown[2] = SEG_BLANK;
                        shown[3] = SEG_BLANK;
                    end
                    5'd3:
                    begin
                        // A middle byte other than L or H leaves the second digit alone.
                        shown[0] = shape_of(line_head[0]);
                        if (line_head[1] == CHAR_L)
                            shown[1] = SEG_L;
                        else if (line_head[1] == CHAR_H)
                            shown[1] = SEG_H;
                        shown[2] = shape_of(line_head[2]);
                        shown[3] = SEG_BLANK;
                    end
                    default:
                    begin
                    end
                endcase
            end
            write_pos = '0;
            text_len  = '0;
            nul_found = 1'b0;
        end
        else if (b == CHAR_CR)
            cr_pending = 1'b1;
        else
        begin
            if (write_pos < 5'd3)
                line_head[write_pos[1:0]] = b;
            if (!nul_found)
            begin
                if (b == CHAR_NUL)
                    nul_found = 1'b1;
                else
                    text_len = text_len + 5'd1;
            end
            // Reaching the line limit starts a fresh line.
            write_pos = write_pos + 5'd1;
            if (write_pos == LINE_LIMIT)
            begin
                write_pos = '0;
                text_len  = '0;
                nul_found = 1'b0;
            end
        end
    endtask

    // Watch every channel at the clock edge and keep the expectations in step.
    always @(posedge clk or negedge rst_n)
    begin
        scan_result_t got;
        scan_result_t want;
        logic [2:0]   sel;
        logic [3:0]   nxt;
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                line_head[i] = '0;
            for (int i = 0; i < NUM_DIGITS; i++)
                shown[i] = SEG_BLANK;
            write_pos     = '0;
            text_len      = '0;
            nul_found     = 1'b0;
            cr_pending    = 1'b0;
            scan_pos      = '0;
            scan_limit    = SCAN_COUNT_RESET;
            select_offset = '0;
            scan_results_due.delete();
            failures      = 0;
            outstanding   = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_SCAN_COUNT)
                    scan_limit = cfg_data;
                else
                    select_offset = cfg_data[2:0];
            end

            // Compare a finished master transaction with the oldest expectation.
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (scan_results_due.size() == 0)
                begin
                    $error("unexpected scan result: m_tdata %h", m_tdata);
                    failures++;
                end
                else
                begin
                    want = scan_results_due.pop_front();
                    if (got.digit_select !== want.digit_select)
                    begin
                        $error("digit_select: expected %h, got %h",
                               want.digit_select, got.digit_select);
                        failures++;
                    end
                    if (got.segments !== want.segments)
                    begin
                        $error("segments: expected %h, got %h", want.segments, got.segments);
                        failures++;
                    end
                end
            end

            // A tick emits the current digit and moves the scan on; a byte feeds the line.
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == REQ_TICK)
                begin
                    sel                = scan_pos + select_offset;
                    want.digit_select  = ~(8'd1 << sel);
                    want.segments      = shown[scan_pos];
                    scan_results_due.push_back(want);
                    nxt = {1'b0, scan_pos} + 4'd1;
                    if (nxt == scan_limit || nxt >= NUM_DIGITS)
                        nxt = '0;
                    scan_pos = nxt[2:0];
                end
                else
                    absorb_rx_byte(s_tdata);
            end

            outstanding = scan_results_due.size();
        end
    end

endmodule

[tb/tb_serial_line_to_seven_segment_core.sv]
// Top of the testbench for serial_line_to_seven_segment_core: clock, reset, command
// line and tick stimulus, receiver back-pressure and the verdict.
// Depends on sl7seg_pkg, sl7seg_tb_pkg, sl7seg_scan_checker and the core.
module tb_serial_line_to_seven_segment_core;
    timeunit 1ns;
    timeprecision 1ps;

    import sl7seg_pkg::*;
    import sl7seg_tb_pkg::*;

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 144;
    localparam int HOLD_CYCLES     = 120;
    localparam int HOLD_TICKS      = 40;
    localparam int SETTLE_CYCLES   = 4;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tuser   = REQ_BYTE;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = CFG_SCAN_COUNT;
    logic [3:0]  cfg_data  = '0;

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_request   = 1'b0;
    int   items_sent     = 0;
    int   failures;
    int   outstanding;

    serial_line_to_seven_segment_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sl7seg_scan_checker u_scan_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .failures    (failures),
        .outstanding (outstanding)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the core hangs.
    initial
    begin
        #2_000_000;
        $display("serial_line_to_seven_segment_core test failed");
        $finish;
    end

    // Receiver: random stalls, or one long hold-off counted here when requested.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one transaction after a random idle stretch and wait for the handshake.
    task automatic push_item(input req_kind_t kind, input logic [7:0] payload);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= payload;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        push_item(REQ_BYTE, b);
    endtask

    // The data bits of a tick are don't-care, so they carry noise.
    task automatic send_tick();
        push_item(REQ_TICK, 8'($urandom_range(255)));
    endtask

    // Stop offering and wait until every tick has come back, then let the pipe settle.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // A byte of line text: mostly digits and command letters, some zero and raw bytes.
    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        case ($urandom_range(11))
            0, 1, 2, 3, 4, 5: b = CHAR_ZERO + 8'($urandom_range(9));
            6:       b = CHAR_L;
            7:       b = CHAR_H;
            8:       b = CHAR_R;
            9:       b = CHAR_NUL;
            default:
            begin
                b = 8'($urandom_range(255));
                if (b == CHAR_CR)
                    b = ~CHAR_CR;
            end
        endcase
        return b;
    endfunction

    // One random line: a short command, an ignored length, a wrapping run, a broken
    // terminator or plain noise, with ticks mixed in and a few ticks after it.
    task automatic send_random_line();
        int         kind_roll;
        int         n;
        logic [7:0] stray;
        kind_roll = $urandom_range(99);
        if (kind_roll < 55)
            n = $urandom_range(3, 1);
        else if (kind_roll < 65)
            n = $urandom_range(8, 4);
        else if (kind_roll < 75)
            n = $urandom_range(2 * LINE_LIMIT_DEFAULT + 5, LINE_LIMIT_DEFAULT - 2);
        else if (kind_roll < 85)
            n = $urandom_range(3);
        else
            n = 0;
        repeat (n)
        begin
            send_byte(text_byte());
            if ($urandom_range(99) < 15)
                send_tick();
        end
        if (kind_roll < 75)
        begin
            send_byte(CHAR_CR);
            send_byte(CHAR_LF);
        end
        else if (kind_roll < 85)
        begin
            stray = 8'($urandom_range(255));
            if (stray == CHAR_LF)
                stray = ~CHAR_LF;
            send_byte(CHAR_CR);
            send_byte(stray);
        end
        else
        begin
            repeat ($urandom_range(4, 1))
                send_byte(8'($urandom_range(255)));
        end
        repeat ($urandom_range(5, 1))
            send_tick();
    endtask

    // Stimulus: directed lines, then random phases with different settings and idling.
    initial
    begin
        int         goal;
        logic [3:0] new_count;
        logic [2:0] new_offset;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Blank display straight after reset.
        send_tick();
        // Rest message.
        send_byte(CHAR_R);
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        send_tick();
        // Three characters with H in the middle and the lowest and highest digits.
        send_byte(CHAR_ZERO);
        send_byte(CHAR_H);
        send_byte(CHAR_NINE);
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        send_tick();
        // Two characters with L second.
        send_byte(CHAR_NINE);
        send_byte(CHAR_L);
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        send_tick();
        // A zero byte cuts the length to one, and the remaining non-digit shows blank.
        send_byte(8'hff);
        send_byte(CHAR_NUL);
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        send_tick();
        // CR followed by something other than LF throws the line away.
        send_byte(CHAR_ZERO + 8'd5);
        send_byte(CHAR_CR);
        send_byte(CHAR_CR);
        send_tick();

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                1:       begin new_count = 4'd1;  new_offset = 3'd7; end
                2:       begin new_count = 4'd3;  new_offset = 3'd2; end
                3:       begin new_count = 4'd8;  new_offset = 3'd7; end
                4:       begin new_count = 4'd5;  new_offset = 3'd0; end
                5:       begin new_count = 4'd0;  new_offset = 3'd4; end
                6:       begin new_count = 4'd15; new_offset = 3'd1; end
                default: begin new_count = 4'd6;  new_offset = 3'd3; end
            endcase

            // Settings change only once the core has gone quiet.
            if (phase != 0)
            begin
                wait_for_results();
                cfg_we    <= 1'b1;
                cfg_index <= CFG_SCAN_COUNT;
                cfg_data  <= new_count;
                @(posedge clk);
                cfg_index <= CFG_FIRST_DIGIT;
                cfg_data  <= {1'b0, new_offset};
                @(posedge clk);
                cfg_we    <= 1'b0;
            end

            case (phase % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase

            // Long receiver hold-off with ticks queued behind it fills the core.
            if (phase == 4)
            begin
                hold_request = 1'b1;
                repeat (HOLD_TICKS) send_tick();
            end

            goal = items_sent + ITEMS_PER_PHASE;
            while (items_sent < goal)
                send_random_line();
        end

        wait_for_results();
        if (failures == 0)
            $display("serial_line_to_seven_segment_core test passed");
        else
            $display("serial_line_to_seven_segment_core test failed");
        $finish;
    end

endmodule

[serial_line_to_seven_segment_core.f]
rtl/sl7seg_pkg.sv
rtl/sl7seg_line.sv
rtl/serial_line_to_seven_segment_core.sv
tb/sl7seg_tb_pkg.sv
tb/sl7seg_scan_checker.sv
tb/tb_serial_line_to_seven_segment_core.sv
